// File: rtl/core/upr_pkg.sv
`timescale 1ns / 1ps
// Package for the pixel replicating upscaler: sizes, codes and word types.
// Used by the channel interfaces and the top level.
package upr_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_SCALE = 64;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int SCALE_W   = 7;
  localparam int WIDTH_W   = 11;
  localparam int CNT_W     = $clog2(MAX_SCALE);
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_idx_t;

  // Input actions.
  typedef enum logic {
    ACT_PIXEL  = 1'b0,
    ACT_REPLAY = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              row_end;
    logic [1:0]        pad_bytes;
    logic              run_last;
  } out_word_t;

endpackage

// File: rtl/core/upr_in_if.sv
`timescale 1ns / 1ps
// Input channel of the upscaler: valid/ready handshake with one input word.
// Depends on upr_pkg for the word type.
interface upr_in_if import upr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/upr_out_if.sv
`timescale 1ns / 1ps
// Result channel of the upscaler: valid/ready handshake with one output word.
// Depends on upr_pkg for the word type.
interface upr_out_if import upr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/upr_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read port.
// Stand-alone; no package needed.
module upr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable with write strobe, otherwise read into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/core/pixel_replicate_upscaler.sv
`timescale 1ns / 1ps
// Top level of the pixel replicating upscaler.
// Depends on upr_pkg, upr_in_if, upr_out_if and the upr_ram line buffer.
//
//   Channel | Direction | Handshake       | Word
//   in_ch   | in        | valid/ready     | action, blue, green, red
//   out_ch  | out       | valid/ready     | out_blue..out_red, row_end, pad_bytes, run_last
//   cfg_*   | in        | write enable    | cfg_idx selects scale or width, cfg_wdata
//
// A source pixel word goes from ST_IDLE straight to ST_EMIT, which emits it scale times;
// a replay word first passes ST_READ, the registered line RAM read. A dropped word emits nothing.
// Input words are taken only while no result run is in progress.
// Reset is synchronous; the line RAM is not cleared and holds garbage until written.
// Stalls on out_ch simply hold the current output word.
module pixel_replicate_upscaler import upr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  upr_in_if.sink                in_ch,
  upr_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [SCALE_W-1:0]  scale_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [CNT_W-1:0]    rows_r, rows_nxt;
  logic                replaying_r, replaying_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    scale_m1_r, scale_m1_nxt;
  logic                line_end_r, line_end_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic [PIX_W-1:0]    pix_r, pix_nxt;

  logic [SCALE_W-1:0]  scale_eff;
  logic [WIDTH_W-1:0]  width_eff;
  logic [1:0]          pad_prod;
  logic                line_end;
  logic                accept;
  logic                run_last;
  logic                ram_en;
  logic                ram_we;
  logic [PIX_W-1:0]    ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_W'(1);
      width_r <= WIDTH_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_SCALE: scale_r <= cfg_wdata[SCALE_W-1:0];
        CFG_WIDTH: width_r <= cfg_wdata[WIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  // Effective scale and width, clamped to their legal ranges.
  always_comb begin
    if (scale_r == '0) begin
      scale_eff = SCALE_W'(1);
    end else if (scale_r > SCALE_W'(MAX_SCALE)) begin
      scale_eff = SCALE_W'(MAX_SCALE);
    end else begin
      scale_eff = scale_r;
    end
    if (width_r == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = width_r;
    end
  end

  // Pad count depends only on the two low bits of scale and width.
  assign pad_prod = scale_eff[1:0] * width_eff[1:0];
  assign line_end = ({1'b0, col_r} + WIDTH_W'(1)) >= width_eff;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign run_last    = (cnt_r == scale_m1_r);

  // Line buffer. Writes happen on source words and reads on replay words, each at
  // acceptance, so one word never writes and reads the same entry in one cycle.
  assign ram_en = accept &&
                  ((in_ch.data.action == ACT_PIXEL  && !replaying_r) ||
                   (in_ch.data.action == ACT_REPLAY &&  replaying_r));
  assign ram_we = (in_ch.data.action == ACT_PIXEL);

  upr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (col_r),
    .wdata ({in_ch.data.red, in_ch.data.green, in_ch.data.blue}),
    .rdata (ram_rdata)
  );

  // Next-state logic: line position and replay bookkeeping update at acceptance.
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    rows_nxt      = rows_r;
    replaying_nxt = replaying_r;
    cnt_nxt       = cnt_r;
    scale_m1_nxt  = scale_m1_r;
    line_end_nxt  = line_end_r;
    pad_nxt       = pad_r;
    pix_nxt       = pix_r;
    case (state_r)
      ST_IDLE: begin
        if (ram_en) begin
          cnt_nxt      = '0;
          scale_m1_nxt = CNT_W'(scale_eff - SCALE_W'(1));
          line_end_nxt = line_end;
          pad_nxt      = pad_prod;
          col_nxt      = line_end ? '0 : col_r + COL_W'(1);
          if (ram_we) begin
            pix_nxt   = {in_ch.data.red, in_ch.data.green, in_ch.data.blue};
            state_nxt = ST_EMIT;
            if (line_end && scale_eff > SCALE_W'(1)) begin
              replaying_nxt = 1'b1;
              rows_nxt      = CNT_W'(scale_eff - SCALE_W'(1));
            end
          end else begin
            state_nxt = ST_READ;
            if (line_end) begin
              if (rows_r > CNT_W'(1)) begin
                rows_nxt = rows_r - CNT_W'(1);
              end else begin
                rows_nxt      = '0;
                replaying_nxt = 1'b0;
              end
            end
          end
        end
      end
      ST_READ: begin
        pix_nxt   = ram_rdata;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          if (run_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      rows_r      <= '0;
      replaying_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      rows_r      <= rows_nxt;
      replaying_r <= replaying_nxt;
      cnt_r       <= cnt_nxt;
    end
    scale_m1_r <= scale_m1_nxt;
    line_end_r <= line_end_nxt;
    pad_r      <= pad_nxt;
    pix_r      <= pix_nxt;
  end

  // Output word, built from the run registers.
  assign out_ch.valid          = (state_r == ST_EMIT);
  assign out_ch.data.out_blue  = pix_r[CHAN_W-1:0];
  assign out_ch.data.out_green = pix_r[2*CHAN_W-1:CHAN_W];
  assign out_ch.data.out_red   = pix_r[PIX_W-1:2*CHAN_W];
  assign out_ch.data.row_end   = run_last && line_end_r;
  assign out_ch.data.pad_bytes = (run_last && line_end_r) ? pad_r : 2'b00;
  assign out_ch.data.run_last  = run_last;

  // A run never exceeds the scale captured for it.
  a_cnt_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (cnt_r <= scale_m1_r))
    else $error("copy counter ran past the end of the run");

  // Replay mode always has rows left to produce.
  a_rows_left: assert property (@(posedge clk) disable iff (!rst_n)
    replaying_r |-> (rows_r != '0))
    else $error("replaying with no rows left");

  // An in-order source word starts its run in the next cycle.
  a_src_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.action == ACT_PIXEL && !replaying_r) |=> out_ch.valid)
    else $error("source word did not start a run");

  // A dropped word leaves the line position untouched.
  a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ram_en) |=> ($stable(col_r) && !out_ch.valid))
    else $error("dropped word changed state or produced a result");

  // The read cycle always hands over to a run.
  a_read_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_ch.valid)
    else $error("line buffer read not followed by a run");

endmodule
